/* rtl/ddcrc_pkg.sv */
// shared constants, codes and types of the ddc/ci reply checker
package ddcrc_pkg;

   // default store depth and frame limits
   localparam int MAX_FRAME_BYTES_DEF = 38;
   localparam int MAX_FRAGMENT_DATA   = 35;
   localparam int VCP_REPLY_BYTES     = 11;
   // payload length width, covers the largest fragment data length less three
   localparam int PLEN_W              = 7;
   // store index of the first capabilities payload byte
   localparam int PAYLOAD_BASE        = 5;

   // frame byte values
   localparam logic [7:0] REPLY_SRC    = 8'h6E;
   localparam logic [7:0] VCP_LEN_BYTE = 8'h88;
   localparam logic [7:0] VCP_CMD      = 8'h02;
   localparam logic [7:0] CAP_CMD      = 8'hE3;
   localparam logic [7:0] XOR_SEED     = 8'h50;

   // expected frame kind
   localparam logic OP_VCP  = 1'b0;
   localparam logic OP_CAPS = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_LENGTH    = 3'd1;
   localparam logic [2:0] ST_SOURCE    = 3'd2;
   localparam logic [2:0] ST_COMMAND   = 3'd3;
   localparam logic [2:0] ST_RESULT    = 3'd4;
   localparam logic [2:0] ST_VCP       = 3'd5;
   localparam logic [2:0] ST_CHECKSUM  = 3'd6;
   localparam logic [2:0] ST_MALFORMED = 3'd7;

   // header bytes captured as they arrive
   typedef struct packed {
      logic [7:0] src;      // byte 0
      logic [7:0] len;      // byte 1
      logic [7:0] cmd;      // byte 2
      logic [7:0] rc;       // byte 3
      logic [7:0] code;     // byte 4
      logic [7:0] max_hi;   // byte 6
      logic [7:0] max_lo;   // byte 7
      logic [7:0] cur_hi;   // byte 8
      logic [7:0] cur_lo;   // byte 9
   } hdr_type;

   // frame totals latched with the final byte
   typedef struct packed {
      logic        op;
      logic [7:0]  n;
      logic        over;
      logic [7:0]  xr;
      logic [7:0]  chk;
      logic [7:0]  rvcp;
      logic [15:0] roff;
   } frame_type;

   // judgement of one frame
   typedef struct packed {
      logic [2:0]        status;
      logic [7:0]        vcp;
      logic [15:0]       max;
      logic [15:0]       cur;
      logic [15:0]       off;
      logic [PLEN_W-1:0] plen;
      logic              more;
   } verdict_type;

endpackage

/* rtl/ddcrc_store.sv */
// frame byte store, one write port and one registered read port
module ddcrc_store
   import ddcrc_pkg::*;
#(
   parameter int DEPTH = MAX_FRAME_BYTES_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ddcrc_judge.sv */
// frame checks and summary fields for get-vcp and capabilities replies
module ddcrc_judge
   import ddcrc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  hdr_type     hdr,
   input  frame_type   frm,
   output verdict_type vrd
);

   logic [6:0]  dlen;
   logic [7:0]  decl;
   logic [15:0] off;
   logic        cap_len_bad;

   // declared capabilities size and offset
   assign dlen = hdr.len[6:0];
   assign decl = {1'b0, dlen} + 8'd3;
   assign off  = {hdr.rc, hdr.code};
   assign cap_len_bad = (dlen < 7'd3) || (dlen > 7'(MAX_FRAGMENT_DATA)) ||
                        (decl != frm.n) || (decl > 8'(MAX_FRAME_BYTES));

   // checks in priority order
   always_comb begin
      vrd = '0;
      if (frm.op == OP_VCP) begin
         if (frm.over || (frm.n != 8'(VCP_REPLY_BYTES))) begin
            vrd.status = ST_LENGTH;
         end else if ((hdr.src != REPLY_SRC) || (hdr.len != VCP_LEN_BYTE)) begin
            vrd.status = ST_SOURCE;
         end else if (hdr.cmd != VCP_CMD) begin
            vrd.status = ST_COMMAND;
         end else if (hdr.rc != 8'd0) begin
            vrd.status = ST_RESULT;
         end else if (hdr.code != frm.rvcp) begin
            vrd.status = ST_VCP;
         end else if (frm.xr != frm.chk) begin
            vrd.status = ST_CHECKSUM;
         end else begin
            vrd.status = ST_OK;
            vrd.vcp    = hdr.code;
            vrd.max    = {hdr.max_hi, hdr.max_lo};
            vrd.cur    = {hdr.cur_hi, hdr.cur_lo};
         end
      end else begin
         if (frm.over || (frm.n < 8'd2)) begin
            vrd.status = ST_MALFORMED;
         end else if ((hdr.src != REPLY_SRC) || !hdr.len[7]) begin
            vrd.status = ST_MALFORMED;
         end else if (cap_len_bad) begin
            vrd.status = ST_MALFORMED;
         end else if (hdr.cmd != CAP_CMD) begin
            vrd.status = ST_MALFORMED;
         end else if (frm.xr != frm.chk) begin
            vrd.status = ST_CHECKSUM;
         end else if (off != frm.roff) begin
            vrd.status = ST_MALFORMED;
         end else begin
            vrd.status = ST_OK;
            vrd.off    = off;
            vrd.plen   = PLEN_W'(dlen - 7'd3);
            vrd.more   = (dlen != 7'd3);
         end
      end
   end

endmodule

/* rtl/ddc_ci_reply_checker.sv */
// ddc/ci reply checker top level: byte intake, judgement and result sequencing
//
//   channel  dir  beat                      tdata / tuser / tlast
//   req_     in   one received frame byte   byte, vcp, offset / opcode / final byte
//   rsp_     out  summary or payload byte   status..payload byte / payload flag / last
//
// non-final bytes are taken while the sequencer is idle; the final byte moves it to the
// judge state, from which the summary is loaded into the output register once it is free.
// each payload byte is a read of the frame store, whose read port is registered,
// then a load into the output register.
// reset is synchronous and clears the control state; the frame store is not cleared,
// since only entries written in the current frame are read.
// a stalled rsp_ side holds the output register and the sequencer; new bytes are taken
// only once all beats of the previous frame are loaded.
module ddc_ci_reply_checker
   import ddcrc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // reply_byte[7:0], asked_vcp[15:8], asked_offset[31:16]
   input  logic        req_tuser,   // opcode
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // status[2:0], code_echo[10:3], max_value[26:11],
                                    // cur_value[42:27], fragment_offset[58:43],
                                    // fragment_length[64:59], payload_byte[72:65], zeros
   output logic        rsp_tuser,   // payload_valid
   output logic        rsp_tlast    // last
);

   localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_JUDGE = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_LOAD  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic [7:0]        xor_ff;
   logic              over_ff, over_in;
   hdr_type           hdr_ff;
   frame_type         frm_ff;
   verdict_type       vrd;
   logic [15:0]       off_ff;
   logic [PLEN_W-1:0] plen_ff;
   logic [PLEN_W-1:0] idx_ff;

   logic              req_accept;
   logic [7:0]        req_byte;
   logic              out_free;
   logic              load_sum;
   logic              load_pay;
   logic              wr_en;
   logic              rd_en;
   logic [7:0]        rd_sum;
   logic [7:0]        rd_data;
   logic              pay_last;

   logic              rsp_valid_ff;
   logic              rsp_last_ff;
   logic              rsp_pv_ff;
   logic [2:0]        rsp_st_ff;
   logic [7:0]        rsp_vcp_ff;
   logic [15:0]       rsp_max_ff;
   logic [15:0]       rsp_cur_ff;
   logic [15:0]       rsp_off_ff;
   logic [5:0]        rsp_flen_ff;
   logic [7:0]        rsp_pb_ff;

   // intake handshake
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_byte   = req_tdata[7:0];

   // count and overflow for the byte being taken
   assign cnt_in  = (cnt_ff != 8'hFF) ? cnt_ff + 8'd1 : cnt_ff;
   assign over_in = over_ff || (cnt_ff >= 8'(MAX_FRAME_BYTES));
   assign wr_en   = req_accept && (cnt_ff < 8'(MAX_FRAME_BYTES));

   // payload read address
   assign rd_en  = (state_ff == S_READ);
   assign rd_sum = 8'(PAYLOAD_BASE) + 8'(idx_ff);

   ddcrc_store #(
      .DEPTH(MAX_FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_sum[AW-1:0]),
      .rd_data (rd_data)
   );

   ddcrc_judge #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_judge (
      .hdr (hdr_ff),
      .frm (frm_ff),
      .vrd (vrd)
   );

   // output register loads
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_sum = (state_ff == S_JUDGE) && out_free;
   assign load_pay = (state_ff == S_LOAD) && out_free;
   assign pay_last = (idx_ff + PLEN_W'(1)) == plen_ff;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_tlast) begin
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            if (load_sum) begin
               state_in = vrd.more ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (load_pay) begin
               state_in = pay_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 8'd0;
         xor_ff       <= XOR_SEED;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            if (req_tlast) begin
               cnt_ff  <= 8'd0;
               xor_ff  <= XOR_SEED;
               over_ff <= 1'b0;
            end else begin
               cnt_ff  <= cnt_in;
               xor_ff  <= xor_ff ^ req_byte;
               over_ff <= over_in;
            end
         end
         if (load_sum || load_pay) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // header capture by byte position
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (cnt_ff == 8'd0) hdr_ff.src    <= req_byte;
         if (cnt_ff == 8'd1) hdr_ff.len    <= req_byte;
         if (cnt_ff == 8'd2) hdr_ff.cmd    <= req_byte;
         if (cnt_ff == 8'd3) hdr_ff.rc     <= req_byte;
         if (cnt_ff == 8'd4) hdr_ff.code   <= req_byte;
         if (cnt_ff == 8'd6) hdr_ff.max_hi <= req_byte;
         if (cnt_ff == 8'd7) hdr_ff.max_lo <= req_byte;
         if (cnt_ff == 8'd8) hdr_ff.cur_hi <= req_byte;
         if (cnt_ff == 8'd9) hdr_ff.cur_lo <= req_byte;
      end
   end

   // frame totals latched with the final byte
   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         frm_ff.op   <= req_tuser;
         frm_ff.n    <= cnt_in;
         frm_ff.over <= over_in;
         frm_ff.xr   <= xor_ff;
         frm_ff.chk  <= req_byte;
         frm_ff.rvcp <= req_tdata[15:8];
         frm_ff.roff <= req_tdata[31:16];
      end
   end

   // payload walk
   always_ff @(posedge clock) begin
      if (load_sum) begin
         off_ff  <= vrd.off;
         plen_ff <= vrd.plen;
         idx_ff  <= '0;
      end else if (load_pay) begin
         idx_ff  <= idx_ff + PLEN_W'(1);
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (load_sum) begin
         rsp_st_ff   <= vrd.status;
         rsp_vcp_ff  <= vrd.vcp;
         rsp_max_ff  <= vrd.max;
         rsp_cur_ff  <= vrd.cur;
         rsp_off_ff  <= vrd.off;
         rsp_flen_ff <= vrd.plen[5:0];
         rsp_pb_ff   <= 8'd0;
         rsp_pv_ff   <= 1'b0;
         rsp_last_ff <= !vrd.more;
      end else if (load_pay) begin
         rsp_st_ff   <= ST_OK;
         rsp_vcp_ff  <= 8'd0;
         rsp_max_ff  <= 16'd0;
         rsp_cur_ff  <= 16'd0;
         rsp_off_ff  <= off_ff;
         rsp_flen_ff <= plen_ff[5:0];
         rsp_pb_ff   <= rd_data;
         rsp_pv_ff   <= 1'b1;
         rsp_last_ff <= pay_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_pv_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_pb_ff, rsp_flen_ff, rsp_off_ff, rsp_cur_ff,
                        rsp_max_ff, rsp_vcp_ff, rsp_st_ff};

   // payload beats only follow a good capabilities summary
   a_pay_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pv_ff |-> rsp_st_ff == ST_OK)
      else $error("payload beat with failing status");

   // a failed frame gives a single summary beat
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_st_ff != ST_OK) |-> rsp_last_ff && !rsp_pv_ff)
      else $error("failed summary without last");

   // the final byte always leads to the judge step
   a_final_judge: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> state_ff == S_JUDGE)
      else $error("final byte not judged");

   // the payload walk stays inside the fragment
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) || (state_ff == S_LOAD) |-> idx_ff < plen_ff)
      else $error("payload index past fragment length");

endmodule
